>>> design/exponential_sine_sweep_generator_core_assert.svh
// Assertion macros for the sweep generator top level
`ifndef EXPONENTIAL_SINE_SWEEP_GENERATOR_CORE_ASSERT_SVH
`define EXPONENTIAL_SINE_SWEEP_GENERATOR_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define ESSG_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define ESSG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/essg_pkg.sv
// Package: constants, types and sine table helpers for the sweep generator
package essg_pkg;

	localparam int TABLE_DEPTH_DEF = 1024;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int PHASE_W = 32;
	localparam int STEP_W  = 31;
	localparam int RATIO_W = 32;
	localparam int FRAC_W  = 30;
	localparam int CFG_W   = 32;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] ONE_Q30     = 64'd1073741824;
	localparam logic [63:0] HALF_Q30    = ONE_Q30 >> 1;

	localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(ONE_Q30);
	localparam logic [STEP_W-1:0]  STEP_MAX    = {STEP_W{1'b1}};

	// request queue between front and back
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	// configuration register map
	typedef enum logic [0:0] {
		REG_START_INC = 1'b0,
		REG_GROWTH    = 1'b1
	} cfg_reg_e;

	typedef struct packed {
		logic restart;
		logic block_last;
	} req_t;

	typedef struct packed {
		logic [STEP_W-1:0]  start_inc;
		logic [RATIO_W-1:0] ratio;
	} cfg_t;

	typedef struct packed {
		logic [FIFO_CNT_W-1:0] cnt;
		logic                  full;
	} fifo_stat_t;

	// sine of x (Q30, 0..pi/2) by Taylor series up to x^15, result Q30
	function automatic logic [63:0] sine_q30(input logic [63:0] x);
		logic        [63:0] x2;
		logic        [63:0] term;
		logic signed [63:0] sum;
		begin
			x2   = (x * x) >> 30;
			term = x;
			sum  = $signed(x);
			term = ((term * x2) >> 30) / 6;   sum = sum - $signed(term);
			term = ((term * x2) >> 30) / 20;  sum = sum + $signed(term);
			term = ((term * x2) >> 30) / 42;  sum = sum - $signed(term);
			term = ((term * x2) >> 30) / 72;  sum = sum + $signed(term);
			term = ((term * x2) >> 30) / 110; sum = sum - $signed(term);
			term = ((term * x2) >> 30) / 156; sum = sum + $signed(term);
			term = ((term * x2) >> 30) / 210; sum = sum - $signed(term);
			if (sum < 0) sum = '0;
			return $unsigned(sum);
		end
	endfunction

	// table entry: sine scaled to amplitude, rounded half up, clamped
	function automatic logic [63:0] rom_entry(input logic [63:0] x, input logic [63:0] amp);
		logic [63:0] v;
		begin
			v = (sine_q30(x) * amp + HALF_Q30) >> 30;
			if (v > amp) v = amp;
			return v;
		end
	endfunction

endpackage

>>> design/essg_if.sv
// Channel interfaces: sample request and sine sample

interface essg_req_if;
	import essg_pkg::*;
	logic valid;
	logic ready;
	logic restart;
	logic block_last;

	modport source (output valid, output restart, output block_last, input ready);
	modport sink   (input valid, input restart, input block_last, output ready);
endinterface

interface essg_smp_if #(
	parameter int SAMPLE_BITS = essg_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          last_of_block;

	modport source (output valid, output sample, output last_of_block, input ready);
	modport sink   (input valid, input sample, input last_of_block, output ready);
endinterface

>>> design/exponential_sine_sweep_generator_core.sv
// Top level of the exponential sine sweep generator
//
//  channel | role   | payload                      | handshake
//  --------+--------+------------------------------+--------------------
//  req     | sink   | restart, block_last          | valid/ready
//  smp     | source | sample (signed), last_of_block | valid/ready
//  cfg     | write  | cfg_idx, cfg_wdata           | cfg_we, no stall
//
// One sample per cycle unless the output stalls; the phase/step loop is
// one 31x32 multiply and one add, closed when a request leaves the queue.
// An accepted request passes the queue and stages s1, s2, s3 to its sample.
// Reset clears phase, step, queue and pipeline; the sine table is constant.
// A stalled sample freezes the back end only; the four-entry request queue
// keeps taking transactions until it is full.

`include "exponential_sine_sweep_generator_core_assert.svh"

module exponential_sine_sweep_generator_core #(
	parameter int TABLE_DEPTH = essg_pkg::TABLE_DEPTH_DEF,
	parameter int SAMPLE_BITS = essg_pkg::SAMPLE_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  essg_pkg::cfg_reg_e         cfg_idx,
	input  logic [essg_pkg::CFG_W-1:0] cfg_wdata,
	essg_req_if.sink                   req,
	essg_smp_if.source                 smp
);
	import essg_pkg::*;

	cfg_t       cfg_q;
	logic       q_valid;
	logic       q_ready;
	req_t       q_item;
	fifo_stat_t fstat;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_inc <= '0;
			cfg_q.ratio     <= RATIO_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_START_INC: cfg_q.start_inc <= cfg_wdata[STEP_W-1:0];
				REG_GROWTH:    cfg_q.ratio     <= cfg_wdata[RATIO_W-1:0];
				default:       cfg_q           <= cfg_q;
			endcase
		end
	end

	essg_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_item  (q_item),
		.stat    (fstat)
	);

	essg_back #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_item  (q_item),
		.smp     (smp)
	);

	// checks
	`ESSG_ASSERT_NOW(a_empty_no_valid, fstat.cnt == '0, !q_valid, "queue empty but back end sees a request")
	`ESSG_ASSERT_NOW(a_stall_holds_back, smp.valid && !smp.ready, !q_ready, "back end pops while output is stalled")
	`ESSG_ASSERT_NOW(a_notready_full, !req.ready, fstat.cnt == FIFO_CNT_W'(FIFO_DEPTH), "request port blocked with room in queue")
	`ESSG_ASSERT_NEXT(a_push_lands, req.valid && req.ready, fstat.cnt != '0, "accepted request missing from queue")

endmodule

>>> design/essg_front.sv
// Front end: takes request transactions into a short queue for the back end
module essg_front (
	input  logic                clk,
	input  logic                arst_n,
	essg_req_if.sink            req,
	output logic                q_valid,
	input  logic                q_ready,
	output essg_pkg::req_t      q_item,
	output essg_pkg::fifo_stat_t stat
);
	import essg_pkg::*;

	req_t                  mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic                  push;
	logic                  pop;
	req_t                  in_item;

	// only bit 0 of each field matters; keep them as flags
	assign in_item.restart    = req.restart;
	assign in_item.block_last = req.block_last;

	assign req.ready = (cnt_q != FIFO_CNT_W'(FIFO_DEPTH));
	assign push      = req.valid && req.ready;
	assign q_valid   = (cnt_q != '0);
	assign pop       = q_valid && q_ready;
	assign q_item    = mem_q[rd_ptr_q];

	assign stat.cnt  = cnt_q;
	assign stat.full = !req.ready;

	// queue storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= in_item;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> design/essg_back.sv
// Back end: phase/step recurrence, quarter-wave lookup and output register
module essg_back #(
	parameter int TABLE_DEPTH = essg_pkg::TABLE_DEPTH_DEF,
	parameter int SAMPLE_BITS = essg_pkg::SAMPLE_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  essg_pkg::cfg_t cfg,
	input  logic           q_valid,
	output logic           q_ready,
	input  essg_pkg::req_t q_item,
	essg_smp_if.source     smp
);
	import essg_pkg::*;

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int MAG_W = SAMPLE_BITS - 1;
	localparam logic [63:0]    AMP64   = (64'd1 << MAG_W) - 64'd1;
	localparam logic [IDX_W:0] DEPTH_C = (IDX_W + 1)'(TABLE_DEPTH);

	typedef logic [MAG_W-1:0] mag_t;
	typedef mag_t rom_arr_t [TABLE_DEPTH];

	function automatic rom_arr_t build_rom();
		rom_arr_t    r;
		logic [63:0] x;
		begin
			for (int k = 0; k < TABLE_DEPTH; k++) begin
				x    = (64'(k) * HALF_PI_Q30) / TABLE_DEPTH;
				r[k] = MAG_W'(rom_entry(x, AMP64));
			end
			return r;
		end
	endfunction

	localparam rom_arr_t QUARTER_SINE_ROM = build_rom();

	// recurrence state
	logic [PHASE_W-1:0] phase_q;
	logic [STEP_W-1:0]  step_q;

	// pipeline stages
	logic               v_s1, v_s2, v_s3;
	logic [PHASE_W-1:0] phase_s1;
	logic               last_s1, last_s2, last_s3;
	mag_t               rom_s2;
	logic               full_s2, neg_s2;
	logic signed [SAMPLE_BITS-1:0] sample_s3;

	logic               adv;
	logic               pop;
	logic [PHASE_W-1:0] phase_cur;
	logic [STEP_W-1:0]  step_cur;
	logic [63:0]        step_prod;
	logic [32:0]        step_rnd;
	logic [STEP_W-1:0]  step_nxt;

	// whole pipeline moves together unless the output holds a stalled sample
	assign adv     = !v_s3 || smp.ready;
	assign q_ready = adv;
	assign pop     = q_valid && adv;

	// restart takes effect before this sample
	assign phase_cur = q_item.restart ? '0 : phase_q;
	assign step_cur  = q_item.restart ? cfg.start_inc : step_q;

	// step * ratio, rounded half up in Q30, saturated at Nyquist
	assign step_prod = 64'(step_cur) * 64'(cfg.ratio) + HALF_Q30;
	assign step_rnd  = step_prod[FRAC_W +: 33];
	assign step_nxt  = (step_rnd[32:STEP_W] != '0) ? STEP_MAX : step_rnd[STEP_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			step_q  <= '0;
		end else if (pop) begin
			phase_q <= phase_cur + PHASE_W'(step_cur);
			step_q  <= step_nxt;
		end
	end

	// table address from the phase fraction and quadrant
	logic [FRAC_W+IDX_W:0] idx_prod;
	logic [IDX_W-1:0]      idx;
	logic [IDX_W:0]        idx_mirror;
	logic [IDX_W-1:0]      rom_addr;
	logic                  quad_odd;

	assign quad_odd   = phase_s1[FRAC_W];
	assign idx_prod   = (FRAC_W + IDX_W + 1)'(phase_s1[FRAC_W-1:0]) * (FRAC_W + IDX_W + 1)'(DEPTH_C);
	assign idx        = idx_prod[FRAC_W +: IDX_W];
	assign idx_mirror = DEPTH_C - (IDX_W + 1)'(idx);
	assign rom_addr   = quad_odd ? idx_mirror[IDX_W-1:0] : idx;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= q_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (adv) begin
			phase_s1  <= phase_cur;
			last_s1   <= q_item.block_last;
			rom_s2    <= QUARTER_SINE_ROM[rom_addr];
			full_s2   <= quad_odd && (idx == '0);
			neg_s2    <= phase_s1[PHASE_W-1];
			last_s2   <= last_s1;
			sample_s3 <= neg_s2 ? -$signed({1'b0, full_s2 ? MAG_W'(AMP64) : rom_s2})
			                    :  $signed({1'b0, full_s2 ? MAG_W'(AMP64) : rom_s2});
			last_s3   <= last_s2;
		end
	end

	assign smp.valid         = v_s3;
	assign smp.sample        = sample_s3;
	assign smp.last_of_block = last_s3;

endmodule

>>> tb/exponential_sine_sweep_generator_core_test.sv
// Testbench for the exponential sine sweep generator: directed table, random sweeps, predictor
module exponential_sine_sweep_generator_core_test;
	import essg_pkg::*;

	localparam int                TABLE_DEPTH   = 1024;
	localparam int                TABLE_AW      = 10;
	localparam int                AMPLITUDE     = 32767;
	localparam longint unsigned   PI_OVER_2_Q30 = 64'd1686629713;
	localparam longint unsigned   ROUND_HALF    = 64'd536870912;
	localparam logic [30:0]       NYQUIST_STEP  = 31'h7FFF_FFFF;
	localparam logic [31:0]       UNITY_RATIO   = 32'h4000_0000;
	localparam int                PHASE_ITEMS   = 215;
	localparam int                LONG_HOLD     = 80;
	localparam int                SETTLE_CYCLES = 8;
	localparam int                TIMEOUT_TU    = 2_000_000;

	typedef struct packed {
		logic signed [15:0] sample;
		logic               last_of_block;
	} sweep_sample_t;

	typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_e;

	// one directed step: either a register write or a sample request
	typedef struct {
		row_kind_e          kind;
		cfg_reg_e           reg_sel;
		logic [31:0]        wdata;
		logic               restart;
		logic               block_last;
		logic               typed;
		logic signed [15:0] want_sample;
	} stim_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	cfg_reg_e             cfg_idx;
	logic [CFG_W-1:0]     cfg_wdata;

	essg_req_if                      req_ch ();
	essg_smp_if #(.SAMPLE_BITS(16))  smp_ch ();

	exponential_sine_sweep_generator_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.smp       (smp_ch)
	);

	// predictor state and configuration copy
	logic [15:0]     quarter_wave [TABLE_DEPTH];
	logic [31:0]     phase_acc;
	logic [30:0]     phase_inc;
	logic [30:0]     start_inc_reg;
	logic [31:0]     ratio_reg;
	sweep_sample_t   pending_samples [$];

	int unsigned     error_count = 0;
	int unsigned     send_gap_pct = 21;
	int unsigned     take_gap_pct = 61;
	bit              long_hold_pending = 1'b0;
	int unsigned     hold_left = 0;

	stim_row_t directed_rows [25] = '{
		'{ROW_ITEM,  REG_START_INC, 32'h0,         1'b0, 1'b0, 1'b1, 16'sd0},
		'{ROW_ITEM,  REG_START_INC, 32'h0,         1'b1, 1'b1, 1'b1, 16'sd0},
		'{ROW_WRITE, REG_START_INC, 32'hC000_0000, 1'b0, 1'b0, 1'b0, 16'sd0},
		'{ROW_ITEM,  REG_START_INC, 32'h0,         1'b1, 1'b0, 1'b1, 16'sd0},
		'{ROW_ITEM,  REG_START_INC, 32'h0,         1'b0, 1'b0, 1'b1, 16'sd32767},
		'{ROW_ITEM,  REG_START_INC, 32'h0,         1'b0, 1'b1, 1'b1, 16'sd0},
		'{ROW_ITEM,  REG_START_INC, 32'h0,         1'b0, 1'b0, 1'b1, -16'sd32767},
		'{ROW_ITEM,  REG_START_INC, 32'h0,         1'b0, 1'b0, 1'b1, 16'sd0},
		'{ROW_WRITE, REG_GROWTH,    32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 16'sd0},
		'{ROW_ITEM,  REG_START_INC, 32'h0,         1'b1, 1'b0, 1'b1, 16'sd0},
		'{ROW_ITEM,  REG_START_INC, 32'h0,         1'b0, 1'b0, 1'b0, 16'sd0},
		'{ROW_ITEM,  REG_START_INC, 32'h0,         1'b0, 1'b0, 1'b0, 16'sd0},
		'{ROW_ITEM,  REG_START_INC, 32'h0,         1'b0, 1'b1, 1'b0, 16'sd0},
		'{ROW_WRITE, REG_GROWTH,    32'h0,         1'b0, 1'b0, 1'b0, 16'sd0},
		'{ROW_ITEM,  REG_START_INC, 32'h0,         1'b0, 1'b0, 1'b0, 16'sd0},
		'{ROW_ITEM,  REG_START_INC, 32'h0,         1'b0, 1'b0, 1'b0, 16'sd0},
		'{ROW_ITEM,  REG_START_INC, 32'h0,         1'b0, 1'b0, 1'b0, 16'sd0},
		'{ROW_WRITE, REG_START_INC, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, 16'sd0},
		'{ROW_ITEM,  REG_START_INC, 32'h0,         1'b0, 1'b0, 1'b0, 16'sd0},
		'{ROW_WRITE, REG_GROWTH,    32'h4000_0000, 1'b0, 1'b0, 1'b0, 16'sd0},
		'{ROW_ITEM,  REG_START_INC, 32'h0,         1'b1, 1'b0, 1'b1, 16'sd0},
		'{ROW_ITEM,  REG_START_INC, 32'h0,         1'b0, 1'b0, 1'b0, 16'sd0},
		'{ROW_ITEM,  REG_START_INC, 32'h0,         1'b0, 1'b1, 1'b0, 16'sd0},
		'{ROW_ITEM,  REG_START_INC, 32'h0,         1'b1, 1'b1, 1'b1, 16'sd0},
		'{ROW_ITEM,  REG_START_INC, 32'h0,         1'b0, 1'b0, 1'b0, 16'sd0}
	};

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// quarter-wave table: Taylor series to x^15 in Q30, scaled and rounded half up
	initial begin : fill_quarter_wave
		longint unsigned k, n, x, x2, term, v;
		longint          acc;
		for (k = 0; k < TABLE_DEPTH; k++) begin
			x    = (k * PI_OVER_2_Q30) / TABLE_DEPTH;
			x2   = (x * x) >> 30;
			term = x;
			acc  = longint'(x);
			for (n = 1; n < 15; n += 2) begin
				term = ((term * x2) >> 30) / ((n + 1) * (n + 2));
				if ((((n + 1) / 2) % 2) == 1)
					acc = acc - longint'(term);
				else
					acc = acc + longint'(term);
			end
			if (acc < 0)
				acc = 0;
			v = ($unsigned(acc) * AMPLITUDE + ROUND_HALF) >> 30;
			if (v > AMPLITUDE)
				v = AMPLITUDE;
			quarter_wave[k] = v[15:0];
		end
	end

	// one sweep step: optional restart, sine of current phase, then phase and step update
	function automatic sweep_sample_t advance_sweep(input logic rs, input logic bl);
		logic [TABLE_AW-1:0] idx;
		logic [15:0]         mag;
		logic [63:0]         grown;
		sweep_sample_t       res;
		if (rs) begin
			phase_acc = '0;
			phase_inc = start_inc_reg;
		end
		idx = phase_acc[29 -: TABLE_AW];
		if (phase_acc[30])
			mag = (idx == 0) ? 16'(AMPLITUDE) : quarter_wave[TABLE_DEPTH - idx];
		else
			mag = quarter_wave[idx];
		res.sample        = phase_acc[31] ? -mag : mag;
		res.last_of_block = bl;
		phase_acc = phase_acc + {1'b0, phase_inc};
		grown = ({33'd0, phase_inc} * {32'd0, ratio_reg} + ROUND_HALF) >> 30;
		phase_inc = (grown > {33'd0, NYQUIST_STEP}) ? NYQUIST_STEP : grown[30:0];
		return res;
	endfunction

	// drop valid and let every expected sample come out, then settle
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (pending_samples.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register write, only ever issued with the block idle
	task automatic write_reg(input cfg_reg_e sel, input logic [31:0] data);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_idx   <= sel;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (sel == REG_START_INC)
			start_inc_reg = data[30:0];
		else
			ratio_reg = data;
	endtask

	// offer one request transaction; on acceptance queue the predicted sample
	task automatic push_request(input logic rs, input logic bl, input logic typed,
			input logic signed [15:0] want);
		sweep_sample_t got;
		while ($urandom_range(99) < send_gap_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.restart    <= rs;
		req_ch.block_last <= bl;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		got = advance_sweep(rs, bl);
		if (typed)
			got.sample = want;
		pending_samples.push_back(got);
	endtask

	// sample sink: check each transaction, then choose ready for the next cycle
	initial begin : sample_sink
		sweep_sample_t want;
		smp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && smp_ch.valid && smp_ch.ready) begin
				if (pending_samples.size() == 0) begin
					$error("sample transaction with no sample expected");
					error_count++;
				end else begin
					want = pending_samples.pop_front();
					if (smp_ch.sample !== want.sample) begin
						$error("sample: expected %0d, actual %0d", want.sample, smp_ch.sample);
						error_count++;
					end
					if (smp_ch.last_of_block !== want.last_of_block) begin
						$error("last_of_block: expected %0b, actual %0b",
							want.last_of_block, smp_ch.last_of_block);
						error_count++;
					end
				end
			end
			if (long_hold_pending) begin
				hold_left = LONG_HOLD;
				long_hold_pending = 1'b0;
			end
			if (hold_left != 0) begin
				smp_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				smp_ch.ready <= ($urandom_range(99) >= take_gap_pct);
			end
		end
	end

	// main sequence: reset, directed table, random sweeps, final verdict
	initial begin : main_sequence
		int   sent;
		int   blk_len;
		logic new_sweep;
		logic noisy;
		logic rs;
		logic bl;
		arst_n            <= 1'b0;
		cfg_we            <= 1'b0;
		cfg_idx           <= REG_START_INC;
		cfg_wdata         <= '0;
		req_ch.valid      <= 1'b0;
		req_ch.restart    <= 1'b0;
		req_ch.block_last <= 1'b0;
		phase_acc     = '0;
		phase_inc     = '0;
		start_inc_reg = '0;
		ratio_reg     = UNITY_RATIO;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r]) begin
			if (directed_rows[r].kind == ROW_WRITE)
				write_reg(directed_rows[r].reg_sel, directed_rows[r].wdata);
			else
				push_request(directed_rows[r].restart, directed_rows[r].block_last,
					directed_rows[r].typed, directed_rows[r].want_sample);
		end

		// random sweeps, one configuration per phase
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					write_reg(REG_START_INC, $urandom);
					write_reg(REG_GROWTH, UNITY_RATIO + $urandom_range(0, 1 << 22));
				end
				1: begin
					write_reg(REG_START_INC, $urandom);
					write_reg(REG_GROWTH, UNITY_RATIO - $urandom_range(0, 1 << 22));
				end
				2: begin
					write_reg(REG_START_INC, $urandom_range(0, 1 << 16));
					write_reg(REG_GROWTH, 32'hFFFF_FFFF);
				end
				3: begin
					write_reg(REG_START_INC, 32'hFFFF_FFFF);
					write_reg(REG_GROWTH, 32'h0);
				end
				4: begin
					write_reg(REG_START_INC, $urandom);
					write_reg(REG_GROWTH, $urandom);
				end
				default: begin
					write_reg(REG_START_INC, $urandom);
					write_reg(REG_GROWTH, UNITY_RATIO);
				end
			endcase
			case (ph / 2)
				0: begin
					send_gap_pct = 21;
					take_gap_pct = 61;
				end
				1: begin
					send_gap_pct = 61;
					take_gap_pct = 21;
				end
				default: begin
					send_gap_pct = 0;
					take_gap_pct = 0;
				end
			endcase
			// blocks of contiguous requests; a few noisy blocks scatter the flags
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				blk_len   = $urandom_range(1, 24);
				new_sweep = ($urandom_range(5) == 0);
				noisy     = ($urandom_range(9) == 0);
				for (int j = 0; j < blk_len; j++) begin
					if (ph == 4 && sent == 40)
						long_hold_pending = 1'b1;
					if (ph == 1 && sent == 100)
						wait_drained();
					rs = (j == 0) ? new_sweep : (noisy && $urandom_range(7) == 0);
					bl = noisy ? 1'($urandom_range(1)) : (j == blk_len - 1);
					push_request(rs, bl, 1'b0, 16'sd0);
					sent++;
				end
			end
		end

		wait_drained();
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// watchdog
	initial begin : watchdog
		#(TIMEOUT_TU);
		$display("Verification failed");
		$finish;
	end

endmodule
